// ===== rtl/mandelbrot_escape_time_color_top_assert.svh =====
// Assertion macros shared by the escape-time color block.
`ifndef MANDELBROT_ESCAPE_TIME_COLOR_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_COLOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MET_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/met_pkg.sv =====
// Shared constants, command type and helper function of the escape-time color block.
package met_pkg;

   // Field widths
   localparam int C_W     = 32;
   localparam int ZOOM_W  = 9;
   localparam int ROUND_W = 10;
   localparam int COLOR_W = 8;

   // Default fraction bits of the coordinates and of z
   localparam int FRAC_BITS_DEF = 28;

   // Widest operand handed to one multiplier in one cycle
   localparam int MUL_W = 32;

   // Round limit is (clamped zoom) * 4 + 20
   localparam int ZOOM_CAP       = 192;
   localparam int ZOOM_SCALE_LOG = 2;
   localparam int LIMIT_BASE     = 20;

   // Color ramp
   localparam int GREEN_STEP = 10;
   localparam int BLUE_STEP  = 20;
   localparam int COLOR_MAX  = 255;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture c, clear z and products
      logic mul_en;     // issue one partial product
      logic acc_en;     // add the registered partial product
      logic acc_first;  // that partial product starts a new sum
      logic add_en;     // form the next z and test for escape
      logic out_load;   // move the finished result to the output register
   } met_cmd_type;

   // log2 of the chunk count that one operand of F+2 bits is cut into
   function automatic int mul_log_chunks(int frac_bits);
      return $clog2((frac_bits + 2 + MUL_W - 1) / MUL_W);
   endfunction

endpackage

// ===== rtl/met_mul.sv =====
// Chunked magnitude multiplier with accumulator, result scaled down by the fraction bits.
module met_mul
   import met_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic [FRAC_BITS+1:0]                            a_mag,
   input  logic [FRAC_BITS+1:0]                            b_mag,
   input  logic [2*mul_log_chunks(FRAC_BITS):0]            mul_step,
   input  logic                                            mul_en,
   input  logic                                            acc_en,
   input  logic                                            acc_first,
   input  logic                                            acc_clr,
   output logic [FRAC_BITS+3:0]                            prod
);

   localparam int LOG_NCH = mul_log_chunks(FRAC_BITS);
   localparam int NCH     = 1 << LOG_NCH;
   localparam int SW      = 2 * LOG_NCH + 1;
   localparam int MW      = FRAC_BITS + 2;
   localparam int PW      = FRAC_BITS + 4;
   localparam int CW      = (MW + NCH - 1) / NCH;
   localparam int XW      = NCH * CW;
   localparam int AW      = 2 * XW;
   localparam int SHW     = $clog2(AW);

   logic [XW-1:0]   a_ext;
   logic [XW-1:0]   b_ext;
   logic [SW-1:0]   ka;
   logic [SW-1:0]   kb;
   logic [SHW-1:0]  a_sh;
   logic [SHW-1:0]  b_sh;
   logic [CW-1:0]   a_chunk;
   logic [CW-1:0]   b_chunk;
   logic [2*CW-1:0] pp_in;
   logic [SHW-1:0]  sh_in;
   logic [2*CW-1:0] pp_ff;
   logic [SHW-1:0]  sh_ff;
   logic [AW-1:0]   acc_ff;
   logic [AW-1:0]   acc_in;

   // Select the chunk pair for this step
   assign a_ext   = XW'(a_mag);
   assign b_ext   = XW'(b_mag);
   assign ka      = mul_step & SW'(NCH - 1);
   assign kb      = mul_step >> LOG_NCH;
   assign a_sh    = SHW'(ka) * SHW'(CW);
   assign b_sh    = SHW'(kb) * SHW'(CW);
   assign a_chunk = CW'(a_ext >> a_sh);
   assign b_chunk = CW'(b_ext >> b_sh);
   assign pp_in   = {{CW{1'b0}}, a_chunk} * {{CW{1'b0}}, b_chunk};
   assign sh_in   = a_sh + b_sh;

   // Shift the partial product into place and accumulate
   always_comb begin
      acc_in = acc_first ? '0 : acc_ff;
      acc_in = acc_in + (AW'(pp_ff) << sh_ff);
   end

   // Hold partial product and running sum
   always_ff @(posedge clock) begin
      if (mul_en) begin
         pp_ff <= pp_in;
         sh_ff <= sh_in;
      end
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // Truncate toward zero: drop the fraction bits of the product
   assign prod = acc_ff[FRAC_BITS +: PW];

endmodule

// ===== rtl/met_dp.sv =====
// Datapath: coordinate and z registers, three multipliers, escape test and color mapping.
module met_dp
   import met_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  met_cmd_type                          cmd,
   input  logic [2*mul_log_chunks(FRAC_BITS):0] mul_step,
   output logic                                 done,
   input  logic signed [C_W-1:0]                req_c_real,
   input  logic signed [C_W-1:0]                req_c_imag,
   input  logic                                 csr_wr_en,
   input  logic signed [ZOOM_W-1:0]             csr_zoom_level,
   output logic [COLOR_W-1:0]                   rsp_red,
   output logic [COLOR_W-1:0]                   rsp_green,
   output logic [COLOR_W-1:0]                   rsp_blue,
   output logic                                 rsp_escaped,
   output logic [ROUND_W-1:0]                   rsp_escape_round
);

   localparam int MW   = FRAC_BITS + 2;
   localparam int PW   = FRAC_BITS + 4;
   localparam int NW   = (FRAC_BITS + 3 > C_W - 1) ? FRAC_BITS + 5 : C_W + 1;
   localparam int CP_W = 14;
   localparam logic signed [NW-1:0] TWO_V  = NW'(2) << FRAC_BITS;
   localparam logic [PW:0]          FOUR_V = (PW + 1)'(1) << (FRAC_BITS + 2);

   logic signed [ZOOM_W-1:0] zoom_ff;
   logic [ZOOM_W-2:0]        zoom_clamp;
   logic [ROUND_W-1:0]       limit;

   logic signed [C_W-1:0]    cr_ff;
   logic signed [C_W-1:0]    ci_ff;
   logic [MW-1:0]            zr_mag_ff;
   logic [MW-1:0]            zi_mag_ff;
   logic                     zr_neg_ff;
   logic                     zi_neg_ff;
   logic [ROUND_W-1:0]       rnd_ff;

   logic [PW-1:0]            p_prod;
   logic [PW-1:0]            sr_prod;
   logic [PW-1:0]            si_prod;

   logic signed [NW-1:0]     p_x;
   logic signed [NW-1:0]     sp_x;
   logic signed [NW-1:0]     sr_x;
   logic signed [NW-1:0]     si_x;
   logic signed [NW-1:0]     cr_x;
   logic signed [NW-1:0]     ci_x;
   logic signed [NW-1:0]     zr_n;
   logic signed [NW-1:0]     zi_n;
   logic [PW:0]              mag_sum;
   logic                     sum_esc;
   logic                     bnd_esc;
   logic [ROUND_W-1:0]       rnd_nx;
   logic                     fin_esc_in;
   logic [ROUND_W-1:0]       fin_rnd_in;

   logic                     fin_esc_ff;
   logic [ROUND_W-1:0]       fin_rnd_ff;
   logic [CP_W-1:0]          green_full;
   logic [CP_W-1:0]          blue_full;
   logic [COLOR_W-1:0]       green_in;
   logic [COLOR_W-1:0]       blue_in;
   logic [COLOR_W-1:0]       rsp_green_ff;
   logic [COLOR_W-1:0]       rsp_blue_ff;
   logic                     rsp_escaped_ff;
   logic [ROUND_W-1:0]       rsp_escape_round_ff;

   // Zoom register
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= '0;
      end else if (csr_wr_en) begin
         zoom_ff <= csr_zoom_level;
      end
   end

   // Clamp zoom to [0, cap] and form the round limit
   always_comb begin
      if (zoom_ff[ZOOM_W-1]) begin
         zoom_clamp = '0;
      end else if (zoom_ff[ZOOM_W-2:0] > (ZOOM_W - 1)'(ZOOM_CAP)) begin
         zoom_clamp = (ZOOM_W - 1)'(ZOOM_CAP);
      end else begin
         zoom_clamp = zoom_ff[ZOOM_W-2:0];
      end
   end
   assign limit = (ROUND_W'(zoom_clamp) << ZOOM_SCALE_LOG) + ROUND_W'(LIMIT_BASE);

   // Products of the current z: zr*zi, zr^2, zi^2
   met_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p (
      .clock     (clock),
      .a_mag     (zr_mag_ff),
      .b_mag     (zi_mag_ff),
      .mul_step  (mul_step),
      .mul_en    (cmd.mul_en),
      .acc_en    (cmd.acc_en),
      .acc_first (cmd.acc_first),
      .acc_clr   (cmd.load),
      .prod      (p_prod)
   );

   met_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sr (
      .clock     (clock),
      .a_mag     (zr_mag_ff),
      .b_mag     (zr_mag_ff),
      .mul_step  (mul_step),
      .mul_en    (cmd.mul_en),
      .acc_en    (cmd.acc_en),
      .acc_first (cmd.acc_first),
      .acc_clr   (cmd.load),
      .prod      (sr_prod)
   );

   met_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_si (
      .clock     (clock),
      .a_mag     (zi_mag_ff),
      .b_mag     (zi_mag_ff),
      .mul_step  (mul_step),
      .mul_en    (cmd.mul_en),
      .acc_en    (cmd.acc_en),
      .acc_first (cmd.acc_first),
      .acc_clr   (cmd.load),
      .prod      (si_prod)
   );

   // Next z from the registered products
   assign p_x  = NW'(signed'({1'b0, p_prod}));
   assign sp_x = (zr_neg_ff ^ zi_neg_ff) ? -p_x : p_x;
   assign sr_x = NW'(signed'({1'b0, sr_prod}));
   assign si_x = NW'(signed'({1'b0, si_prod}));
   assign cr_x = NW'(cr_ff);
   assign ci_x = NW'(ci_ff);
   assign zr_n = sr_x - si_x + cr_x;
   assign zi_n = (sp_x <<< 1) + ci_x;

   // Escape tests: squared magnitude of the held z, then components of the new z
   assign mag_sum = (PW + 1)'(sr_prod) + (PW + 1)'(si_prod);
   assign sum_esc = mag_sum > FOUR_V;
   assign bnd_esc = (zr_n > TWO_V) || (zr_n < -TWO_V) || (zi_n > TWO_V) || (zi_n < -TWO_V);
   assign rnd_nx  = rnd_ff + ROUND_W'(1);

   // Decide the round outcome
   always_comb begin
      done       = 1'b0;
      fin_esc_in = 1'b0;
      fin_rnd_in = '0;
      if (sum_esc) begin
         done       = 1'b1;
         fin_esc_in = 1'b1;
         fin_rnd_in = rnd_ff;
      end else if (rnd_nx == limit) begin
         done = 1'b1;
      end else if (bnd_esc) begin
         done       = 1'b1;
         fin_esc_in = 1'b1;
         fin_rnd_in = rnd_nx;
      end
   end

   // Hold c, z and the round index; the index starts one below zero
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cr_ff     <= req_c_real;
         ci_ff     <= req_c_imag;
         zr_mag_ff <= '0;
         zi_mag_ff <= '0;
         zr_neg_ff <= 1'b0;
         zi_neg_ff <= 1'b0;
         rnd_ff    <= '1;
      end else if (cmd.add_en) begin
         fin_esc_ff <= fin_esc_in;
         fin_rnd_ff <= fin_rnd_in;
         if (!done) begin
            zr_mag_ff <= MW'(zr_n[NW-1] ? -zr_n : zr_n);
            zi_mag_ff <= MW'(zi_n[NW-1] ? -zi_n : zi_n);
            zr_neg_ff <= zr_n[NW-1];
            zi_neg_ff <= zi_n[NW-1];
            rnd_ff    <= rnd_nx;
         end
      end
   end

   // Color ramp, saturated; a bounded point has round zero and maps to black
   assign green_full = CP_W'(fin_rnd_ff) * CP_W'(GREEN_STEP);
   assign blue_full  = CP_W'(fin_rnd_ff) * CP_W'(BLUE_STEP);
   assign green_in   = (green_full > CP_W'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX)
                                                       : green_full[COLOR_W-1:0];
   assign blue_in    = (blue_full > CP_W'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX)
                                                      : blue_full[COLOR_W-1:0];

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_green_ff        <= green_in;
         rsp_blue_ff         <= blue_in;
         rsp_escaped_ff      <= fin_esc_ff;
         rsp_escape_round_ff <= fin_rnd_ff;
      end
   end

   assign rsp_red          = '0;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_escaped      = rsp_escaped_ff;
   assign rsp_escape_round = rsp_escape_round_ff;

endmodule

// ===== rtl/met_ctrl.sv =====
// Controller: sequences load, multiply, accumulate, update and output of one point.
`include "mandelbrot_escape_time_color_top_assert.svh"

module met_ctrl
   import met_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 done,
   output met_cmd_type                          cmd,
   output logic [2*mul_log_chunks(FRAC_BITS):0] mul_step
);

   localparam int LOG_NCH = mul_log_chunks(FRAC_BITS);
   localparam int NSTEP   = 1 << (2 * LOG_NCH);
   localparam int SW      = 2 * LOG_NCH + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADD  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]    state_ff;
   logic [2:0]    state_in;
   logic [SW-1:0] step_ff;
   logic [SW-1:0] step_in;
   logic          acc_en_ff;
   logic          acc_first_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.acc_en    = acc_en_ff;
      cmd.acc_first = acc_first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            if (done) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
               step_in  = '0;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (step_ff == SW'(NSTEP - 1)) begin
               state_in = ST_ACC;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_ACC: begin
            state_in = ST_ADD;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         acc_en_ff    <= 1'b0;
         acc_first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         acc_en_ff    <= cmd.mul_en;
         acc_first_ff <= cmd.mul_en && (step_ff == '0);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign mul_step  = step_ff;

   `MET_ASSERT_IMPLY(a_out_no_overwrite, cmd.out_load, !rsp_valid_ff || !rsp_stall, "result overwritten while stalled")
   `MET_ASSERT_IMPLY(a_load_on_accept, cmd.load, req_valid && !req_stall, "load without accepted transaction")
   `MET_ASSERT_NEXT(a_mul_then_acc, cmd.mul_en, cmd.acc_en, "partial product not accumulated")
   `MET_ASSERT_NEXT(a_add_continue, (state_ff == ST_ADD) && !done, state_ff == ST_MUL, "round did not continue")

endmodule

// ===== rtl/mandelbrot_escape_time_color_top.sv =====
// Each round runs the update, multiply and accumulate states, the multiply state once for each
//   of the S partial products per multiply (1 at the default fraction width). A bounded point
//   runs L rounds, L = round limit. One point at a time: the next transaction can be taken in
//   the cycle after the result moves to the output register.
// Reset: synchronous, active high; clears the controller, output valid and zoom to 0.
// Top level of the Mandelbrot escape-time color block.
module mandelbrot_escape_time_color_top
   import met_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [C_W-1:0]    req_c_real,
   input  logic signed [C_W-1:0]    req_c_imag,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COLOR_W-1:0]       rsp_red,
   output logic [COLOR_W-1:0]       rsp_green,
   output logic [COLOR_W-1:0]       rsp_blue,
   output logic                     rsp_escaped,
   output logic [ROUND_W-1:0]       rsp_escape_round,
   input  logic                     csr_wr_en,
   input  logic signed [ZOOM_W-1:0] csr_zoom_level
);

   localparam int SW = 2 * mul_log_chunks(FRAC_BITS) + 1;

   met_cmd_type   cmd;
   logic [SW-1:0] mul_step;
   logic          done;

   // Sequencer
   met_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .done      (done),
      .cmd       (cmd),
      .mul_step  (mul_step)
   );

   // Arithmetic and result registers
   met_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .mul_step         (mul_step),
      .done             (done),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .csr_wr_en        (csr_wr_en),
      .csr_zoom_level   (csr_zoom_level),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_escaped      (rsp_escaped),
      .rsp_escape_round (rsp_escape_round)
   );

endmodule
